>>> design/pdnc_pkg.sv
// Shared types and constants for the perspective divide block.
// No dependencies.
package pdnc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 49;
    localparam int QI_BITS   = OUT_W - FRAC_BITS;        // integer quotient bits kept
    localparam int QW        = QI_BITS + FRAC_BITS + 1;  // plus one rounding bit
    localparam int DEN_W     = 31;
    localparam int DVD_HI    = 62;                       // top magnitude bit

    localparam logic [1:0] REG_BEYOND = 2'd0;
    localparam logic [1:0] REG_BEHIND = 2'd1;
    localparam logic [1:0] REG_NEAR   = 2'd2;

    localparam logic [1:0] CFG_H     = 2'd0;
    localparam logic [1:0] CFG_NEAR  = 2'd1;
    localparam logic [1:0] CFG_OFF_X = 2'd2;
    localparam logic [1:0] CFG_OFF_Y = 2'd3;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        ovf_x;
        logic        ovf_y;
        logic [1:0]  region;
        logic [31:0] depth;
    } side_t;

endpackage

>>> design/pdnc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pdnc_pkg.
module pdnc_divider
    import pdnc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [DEN_W-1:0] den_in,
    input  logic [QW-1:0]    dvd_in,
    output logic [QW-1:0]    q_out
);

    logic [DEN_W-1:0] rem_reg [0:QW];
    logic [DEN_W-1:0] den_reg [0:QW];
    logic [QW-1:0]    dvd_reg [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];

    always_comb
    begin
        rem_reg[0] = rem_in;
        den_reg[0] = den_in;
        dvd_reg[0] = dvd_in;
        q_reg[0]   = '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb
        begin
            shifted = {rem_reg[k], dvd_reg[k][QW-1]};
            trial   = shifted - {1'b0, den_reg[k]};
            ge      = (shifted >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[k+1] <= den_reg[k];
                dvd_reg[k+1] <= {dvd_reg[k][QW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QW-2:0], ge};
            end
        end
    end

    assign q_out = q_reg[QW];

endmodule

>>> design/perspective_divide_near_clamp_unit.sv
// Top level: APB registers, multiply, near-plane select, two divider lanes,
// rounding, offset and saturation. Depends on pdnc_pkg and pdnc_divider.
// Pipeline order: multiply, select, 50 divider stages, round, offset/saturate.
// Throughput: one word per cycle, set by the one-bit-per-stage divider
// pipelines. The whole pipe holds when the output word is stalled. Reset
// (rst_n low, async) clears valid bits and loads h=1000, near=500, offsets 0.
module perspective_divide_near_clamp_unit
    import pdnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] vertex_x,
    input  logic [31:0] vertex_y,
    input  logic [31:0] vertex_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [48:0] screen_x,
    output logic [48:0] screen_y,
    output logic [31:0] screen_depth,
    output logic [1:0]  clip_region
);

    logic [31:0]      h_reg;
    logic [DEN_W-1:0] near_reg;
    logic [31:0]      offx_reg;
    logic [31:0]      offy_reg;
    logic             en;

    assign pready   = 1'b1;
    assign en       = out_ready | ~out_valid;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= 32'd1000;
            near_reg <= 31'd500;
            offx_reg <= '0;
            offy_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                CFG_H:     h_reg    <= pwdata;
                CFG_NEAR:  near_reg <= pwdata[DEN_W-1:0];
                CFG_OFF_X: offx_reg <= pwdata;
                CFG_OFF_Y: offy_reg <= pwdata;
                default:   h_reg    <= h_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            CFG_H:     prdata = h_reg;
            CFG_NEAR:  prdata = {1'b0, near_reg};
            CFG_OFF_X: prdata = offx_reg;
            CFG_OFF_Y: prdata = offy_reg;
            default:   prdata = '0;
        endcase
    end

    // stage 1: products, region, divisor
    logic [DEN_W-1:0] nearv;
    logic [1:0]       region_next;
    logic             v1_reg;
    logic [63:0]      px_reg, py_reg;
    logic [DEN_W-1:0] den1_reg;
    logic [1:0]       region1_reg;
    logic [31:0]      depth1_reg;

    always_comb
    begin
        nearv = (near_reg == '0) ? DEN_W'(1) : near_reg;
        if ($signed(vertex_z) >= $signed({1'b0, nearv}))
            region_next = REG_BEYOND;
        else if ($signed(vertex_z) <= 32'sd0)
            region_next = REG_BEHIND;
        else
            region_next = REG_NEAR;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg      <= 64'($signed(h_reg) * $signed(vertex_x));
            py_reg      <= 64'($signed(h_reg) * $signed(vertex_y));
            den1_reg    <= (region_next == REG_BEYOND) ? vertex_z[DEN_W-1:0] : nearv;
            region1_reg <= region_next;
            depth1_reg  <= (region_next == REG_BEHIND) ? 32'd0 : vertex_z;
        end
    end

    // stage 2: numerator select, magnitude, overflow check
    logic             v2_reg;
    logic [63:0]      numx, numy, magx, magy;
    logic [DEN_W-1:0] den2_reg;
    logic [DEN_W-1:0] remx_reg, remy_reg;
    logic [QW-1:0]    dvdx_reg, dvdy_reg;
    side_t            side2_reg;

    always_comb
    begin
        numx = (region1_reg == REG_NEAR) ? px_reg : {{32{px_reg[31]}}, px_reg[31:0]};
        numy = (region1_reg == REG_NEAR) ? py_reg : {{32{py_reg[31]}}, py_reg[31:0]};
        magx = numx[63] ? (64'd0 - numx) : numx;
        magy = numy[63] ? (64'd0 - numy) : numy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den2_reg         <= den1_reg;
            remx_reg         <= {1'b0, magx[DVD_HI:QI_BITS]};
            remy_reg         <= {1'b0, magy[DVD_HI:QI_BITS]};
            dvdx_reg         <= {magx[QI_BITS-1:0], {(FRAC_BITS+1){1'b0}}};
            dvdy_reg         <= {magy[QI_BITS-1:0], {(FRAC_BITS+1){1'b0}}};
            side2_reg.neg_x  <= numx[63];
            side2_reg.neg_y  <= numy[63];
            side2_reg.ovf_x  <= ({1'b0, magx[DVD_HI:QI_BITS]} >= den1_reg);
            side2_reg.ovf_y  <= ({1'b0, magy[DVD_HI:QI_BITS]} >= den1_reg);
            side2_reg.region <= region1_reg;
            side2_reg.depth  <= depth1_reg;
        end
    end

    // divider lanes
    logic [QW-1:0] qx, qy;

    pdnc_divider u_div_x (
        .clk    (clk),
        .en     (en),
        .rem_in (remx_reg),
        .den_in (den2_reg),
        .dvd_in (dvdx_reg),
        .q_out  (qx)
    );

    pdnc_divider u_div_y (
        .clk    (clk),
        .en     (en),
        .rem_in (remy_reg),
        .den_in (den2_reg),
        .dvd_in (dvdy_reg),
        .q_out  (qy)
    );

    side_t side_reg [0:QW];
    logic  vd_reg   [0:QW];

    always_comb
    begin
        side_reg[0] = side2_reg;
        vd_reg[0]   = v2_reg;
    end

    for (genvar k = 0; k < QW; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[k+1] <= side_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[k+1] <= 1'b0;
            else if (en)
                vd_reg[k+1] <= vd_reg[k];
        end
    end

    // stage 3: round and apply sign
    logic              v3_reg;
    logic signed [50:0] sx3_reg, sy3_reg;
    side_t             side3_reg;
    logic [QW-1:0]     valx, valy;

    always_comb
    begin
        valx = {1'b0, qx[QW-1:1]} + {{(QW-1){1'b0}}, qx[0]};
        valy = {1'b0, qy[QW-1:1]} + {{(QW-1){1'b0}}, qy[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx3_reg   <= side_reg[QW].neg_x ? -$signed({1'b0, valx}) : $signed({1'b0, valx});
            sy3_reg   <= side_reg[QW].neg_y ? -$signed({1'b0, valy}) : $signed({1'b0, valy});
            side3_reg <= side_reg[QW];
        end
    end

    // stage 4: offset and saturate
    localparam logic signed [51:0] OMAX = 52'sd281474976710655;
    localparam logic signed [51:0] OMIN = -52'sd281474976710656;

    logic signed [51:0] sumx, sumy;
    logic [48:0]        satx, saty;

    always_comb
    begin
        sumx = 52'(sx3_reg) + 52'($signed({offx_reg, {FRAC_BITS{1'b0}}}));
        sumy = 52'(sy3_reg) + 52'($signed({offy_reg, {FRAC_BITS{1'b0}}}));
        if (side3_reg.ovf_x)
            satx = side3_reg.neg_x ? OMIN[48:0] : OMAX[48:0];
        else if (sumx > OMAX)
            satx = OMAX[48:0];
        else if (sumx < OMIN)
            satx = OMIN[48:0];
        else
            satx = sumx[48:0];
        if (side3_reg.ovf_y)
            saty = side3_reg.neg_y ? OMIN[48:0] : OMAX[48:0];
        else if (sumy > OMAX)
            saty = OMAX[48:0];
        else if (sumy < OMIN)
            saty = OMIN[48:0];
        else
            saty = sumy[48:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            screen_x     <= satx;
            screen_y     <= saty;
            screen_depth <= side3_reg.depth;
            clip_region  <= side3_reg.region;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= vd_reg[QW];
            out_valid <= v3_reg;
        end
    end

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (clip_region != 2'd3))
        else $error("bad clip region");

    a_behind_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clip_region == REG_BEHIND) |-> (screen_depth == 32'd0))
        else $error("depth not zero behind eye");

    a_beyond_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clip_region == REG_BEYOND) |-> !screen_depth[31])
        else $error("negative depth beyond near plane");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en) |=> v1_reg)
        else $error("stage one lost a word in a stall");

endmodule
